FILE: sv/tpr_pkg.sv
package tpr_pkg;

   localparam int ENTRIES_DEF = 48;
   localparam int IDX_W       = 6;
   localparam int VPN_W       = 19;
   localparam int ASID_W      = 8;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_PROBE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [31:0] HI_CLEAR = 32'h0000_1f00;

   typedef struct packed {
      logic [31:0] page_mask;
      logic [31:0] entry_hi;
      logic [31:0] entry_lo0;
      logic [31:0] entry_lo1;
   } raw_type;

   typedef struct packed {
      logic [VPN_W-1:0]  vpn2;
      logic [VPN_W-1:0]  mask;
      logic              glob;
      logic [ASID_W-1:0] asid;
   } match_type;

   typedef struct packed {
      logic             probe_miss;
      logic [IDX_W-1:0] probe_index;
      logic [31:0]      page_mask;
      logic [31:0]      entry_hi;
      logic [31:0]      entry_lo0;
      logic [31:0]      entry_lo1;
      logic             index_bad;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic rd_result;
      logic scan;
      logic probe_done;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       scan_hit;
      logic       scan_last;
   } sts_type;

endpackage

FILE: sv/tpr_dp.sv
module tpr_dp #(
   parameter int ENTRIES = tpr_pkg::ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tpr_pkg::cmd_type              cmd,
   output tpr_pkg::sts_type              sts,
   input  logic [1:0]                    req_func,
   input  logic [tpr_pkg::IDX_W-1:0]     req_entry_index,
   input  logic [31:0]                   req_entry_hi,
   input  logic [31:0]                   req_page_mask,
   input  logic [31:0]                   req_entry_lo0,
   input  logic [31:0]                   req_entry_lo1,
   input  logic [tpr_pkg::VPN_W-1:0]     req_vpn2_field,
   input  logic [tpr_pkg::VPN_W-1:0]     req_vpn_mask_field,
   input  logic                          req_global_bit,
   input  logic [tpr_pkg::ASID_W-1:0]    req_asid_field,
   output logic                          rsp_probe_miss,
   output logic [tpr_pkg::IDX_W-1:0]     rsp_probe_index,
   output logic [31:0]                   rsp_read_page_mask,
   output logic [31:0]                   rsp_read_entry_hi,
   output logic [31:0]                   rsp_read_entry_lo0,
   output logic [31:0]                   rsp_read_entry_lo1,
   output logic                          rsp_index_bad
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   // captured transaction
   logic [1:0]                    func_ff;
   logic [tpr_pkg::IDX_W-1:0]     idx_ff;
   tpr_pkg::raw_type              raw_ff;
   tpr_pkg::match_type            fld_ff;

   // table storage
   tpr_pkg::raw_type              raw_mem [ENTRIES];
   tpr_pkg::match_type            match_mem [ENTRIES];
   logic [ENTRIES-1:0]            vld_ff;
   logic [ENTRIES-1:0]            vld_in;

   tpr_pkg::raw_type              rd_raw_ff;
   tpr_pkg::match_type            rd_match_ff;
   logic                          rd_vld_ff;

   logic [CW-1:0]                 scan_ff;
   logic [CW-1:0]                 scan_in;
   logic                          cmp_vld_ff;
   logic [AW-1:0]                 cmp_idx_ff;

   tpr_pkg::rsp_type              res_ff;
   tpr_pkg::rsp_type              res_in;
   tpr_pkg::rsp_type              out_ff;

   logic                          idx_ok;
   logic                          mem_we;
   logic                          scan_issue;
   logic                          rd_en;
   logic [AW-1:0]                 rd_addr;
   tpr_pkg::raw_type              eff_raw;
   tpr_pkg::match_type            eff_match;
   logic                          ent_match;
   logic                          gbit;

   assign idx_ok     = {1'b0, idx_ff} < (tpr_pkg::IDX_W + 1)'(ENTRIES);
   assign mem_we     = cmd.exec && (func_ff == tpr_pkg::FUNC_WRITE) && idx_ok;
   assign scan_issue = cmd.scan && (scan_ff < CW'(ENTRIES));
   assign rd_en      = (cmd.exec && (func_ff == tpr_pkg::FUNC_READ) && idx_ok) || scan_issue;
   assign rd_addr    = cmd.exec ? idx_ff[AW-1:0] : scan_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff          <= req_func;
         idx_ff           <= req_entry_index;
         raw_ff.page_mask <= req_page_mask;
         raw_ff.entry_hi  <= req_entry_hi;
         raw_ff.entry_lo0 <= req_entry_lo0;
         raw_ff.entry_lo1 <= req_entry_lo1;
         fld_ff.vpn2      <= req_vpn2_field;
         fld_ff.mask      <= req_vpn_mask_field;
         fld_ff.glob      <= req_global_bit;
         fld_ff.asid      <= req_asid_field;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         raw_mem[idx_ff[AW-1:0]]   <= raw_ff;
         match_mem[idx_ff[AW-1:0]] <= fld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_raw_ff   <= raw_mem[rd_addr];
         rd_match_ff <= match_mem[rd_addr];
      end
   end

   // entries never written read as zero
   always_comb begin
      vld_in = vld_ff;
      if (mem_we) begin
         vld_in[idx_ff[AW-1:0]] = 1'b1;
      end
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.exec) begin
         scan_in = '0;
      end else if (scan_issue) begin
         scan_in = scan_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         scan_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         scan_ff    <= scan_in;
         cmp_vld_ff <= scan_issue;
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_issue) begin
         cmp_idx_ff <= scan_ff[AW-1:0];
      end
   end

   assign eff_raw   = rd_vld_ff ? rd_raw_ff : '0;
   assign eff_match = rd_vld_ff ? rd_match_ff : '0;
   assign gbit      = eff_raw.entry_hi[12];

   assign ent_match = (eff_match.vpn2 == (~eff_match.mask & raw_ff.entry_hi[tpr_pkg::VPN_W-1:0]))
                   && (eff_match.glob || (eff_match.asid == raw_ff.entry_hi[31:24]));

   assign sts.func      = func_ff;
   assign sts.scan_hit  = cmp_vld_ff && ent_match;
   assign sts.scan_last = cmp_vld_ff && (cmp_idx_ff == AW'(ENTRIES - 1));

   always_comb begin
      res_in = res_ff;
      priority if (cmd.exec) begin
         if ((func_ff == tpr_pkg::FUNC_WRITE) || (func_ff == tpr_pkg::FUNC_PROBE)
             || (func_ff == tpr_pkg::FUNC_READ)) begin
            res_in = '0;
            res_in.index_bad = (func_ff != tpr_pkg::FUNC_PROBE) && !idx_ok;
         end else begin
            res_in = '0;
         end
      end else if (cmd.rd_result) begin
         res_in = '0;
         if (idx_ok) begin
            res_in.page_mask = eff_raw.page_mask;
            res_in.entry_hi  = eff_raw.entry_hi & ~(eff_raw.page_mask | tpr_pkg::HI_CLEAR);
            res_in.entry_lo0 = {eff_raw.entry_lo0[31:1], gbit};
            res_in.entry_lo1 = {eff_raw.entry_lo1[31:1], gbit};
         end else begin
            res_in.index_bad = 1'b1;
         end
      end else if (cmd.probe_done) begin
         res_in = '0;
         res_in.probe_miss = !sts.scan_hit;
         if (sts.scan_hit) begin
            res_in.probe_index = tpr_pkg::IDX_W'(cmp_idx_ff);
         end
      end else begin
         res_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (cmd.load_rsp) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_probe_miss     = out_ff.probe_miss;
   assign rsp_probe_index    = out_ff.probe_index;
   assign rsp_read_page_mask = out_ff.page_mask;
   assign rsp_read_entry_hi  = out_ff.entry_hi;
   assign rsp_read_entry_lo0 = out_ff.entry_lo0;
   assign rsp_read_entry_lo1 = out_ff.entry_lo1;
   assign rsp_index_bad      = out_ff.index_bad;

   // a compare slot always follows an issued scan read
   a_cmp_after_issue: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> $past(cmd.scan))
      else $error("compare slot without a scan read");

   // the table is only written at an in-range index
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      $past(mem_we) |-> ({1'b0, $past(idx_ff)} < (tpr_pkg::IDX_W + 1)'(ENTRIES)))
      else $error("table written beyond its depth");

endmodule

FILE: sv/tpr_ctrl.sv
module tpr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tpr_pkg::cmd_type cmd,
   input  tpr_pkg::sts_type sts
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_RDWAIT = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            priority if (sts.func == tpr_pkg::FUNC_READ) begin
               state_in = ST_RDWAIT;
            end else if (sts.func == tpr_pkg::FUNC_PROBE) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RDWAIT: begin
            cmd.rd_result = 1'b1;
            state_in      = ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_hit || sts.scan_last) begin
               cmd.probe_done = 1'b1;
               state_in       = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // one transaction in flight: nothing accepted the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction taken while busy");

   // a response only appears out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside done state");

   // a probe only misses once the last entry has been compared
   a_miss_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.probe_done && !sts.scan_hit) |-> sts.scan_last)
      else $error("probe miss before the scan finished");

endmodule

FILE: sv/tlb_probe_and_read.sv
// From acceptance to rsp_valid: write and unused code pass the execute and done states,
// a read also the read-wait state, a probe scans until a hit or, on a miss, the last entry.
// The probe walks the table one entry per cycle through the registered table read port.
// One transaction at a time: the next is taken the cycle after its response is registered,
// while that response waits in the output register.
// Reset (synchronous): entry valid bits clear at once, the table reads as zero, no sweep.
module tlb_probe_and_read #(
   parameter int ENTRIES = tpr_pkg::ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic [tpr_pkg::IDX_W-1:0]     req_entry_index,
   input  logic [31:0]                   req_entry_hi,
   input  logic [31:0]                   req_page_mask,
   input  logic [31:0]                   req_entry_lo0,
   input  logic [31:0]                   req_entry_lo1,
   input  logic [tpr_pkg::VPN_W-1:0]     req_vpn2_field,
   input  logic [tpr_pkg::VPN_W-1:0]     req_vpn_mask_field,
   input  logic                          req_global_bit,
   input  logic [tpr_pkg::ASID_W-1:0]    req_asid_field,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_probe_miss,
   output logic [tpr_pkg::IDX_W-1:0]     rsp_probe_index,
   output logic [31:0]                   rsp_read_page_mask,
   output logic [31:0]                   rsp_read_entry_hi,
   output logic [31:0]                   rsp_read_entry_lo0,
   output logic [31:0]                   rsp_read_entry_lo1,
   output logic                          rsp_index_bad
);

   tpr_pkg::cmd_type cmd;
   tpr_pkg::sts_type sts;

   tpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   tpr_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_func           (req_func),
      .req_entry_index    (req_entry_index),
      .req_entry_hi       (req_entry_hi),
      .req_page_mask      (req_page_mask),
      .req_entry_lo0      (req_entry_lo0),
      .req_entry_lo1      (req_entry_lo1),
      .req_vpn2_field     (req_vpn2_field),
      .req_vpn_mask_field (req_vpn_mask_field),
      .req_global_bit     (req_global_bit),
      .req_asid_field     (req_asid_field),
      .rsp_probe_miss     (rsp_probe_miss),
      .rsp_probe_index    (rsp_probe_index),
      .rsp_read_page_mask (rsp_read_page_mask),
      .rsp_read_entry_hi  (rsp_read_entry_hi),
      .rsp_read_entry_lo0 (rsp_read_entry_lo0),
      .rsp_read_entry_lo1 (rsp_read_entry_lo1),
      .rsp_index_bad      (rsp_index_bad)
   );

endmodule

FILE: test/tlb_probe_and_read_checker.sv
`timescale 1ns / 1ps

module tlb_probe_and_read_checker #(
   parameter int ENTRIES = tpr_pkg::ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [1:0]                 req_func,
   input  logic [tpr_pkg::IDX_W-1:0]  req_entry_index,
   input  logic [31:0]                req_entry_hi,
   input  logic [31:0]                req_page_mask,
   input  logic [31:0]                req_entry_lo0,
   input  logic [31:0]                req_entry_lo1,
   input  logic [tpr_pkg::VPN_W-1:0]  req_vpn2_field,
   input  logic [tpr_pkg::VPN_W-1:0]  req_vpn_mask_field,
   input  logic                       req_global_bit,
   input  logic [tpr_pkg::ASID_W-1:0] req_asid_field,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_probe_miss,
   input  logic [tpr_pkg::IDX_W-1:0]  rsp_probe_index,
   input  logic [31:0]                rsp_read_page_mask,
   input  logic [31:0]                rsp_read_entry_hi,
   input  logic [31:0]                rsp_read_entry_lo0,
   input  logic [31:0]                rsp_read_entry_lo1,
   input  logic                       rsp_index_bad,
   output int                         fail_count,
   output int                         outstanding
);

   tpr_pkg::raw_type   tlb_words[ENTRIES];
   tpr_pkg::match_type tlb_tags[ENTRIES];
   tpr_pkg::rsp_type   awaited_rsps[$];
   tpr_pkg::rsp_type   want;
   int                 slot;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] exp_val);
      $display("%0t: %s mismatch, got %h, expected %h", $realtime, what, got, exp_val);
      fail_count++;
   endtask

   // Applies one transaction to the table copy and returns the response it should give.
   function automatic tpr_pkg::rsp_type apply_tlb_op(input logic [1:0] op,
                                            input logic [tpr_pkg::IDX_W-1:0] idx,
                                            input logic [31:0] hi, pm, lo0, lo1,
                                            input logic [tpr_pkg::VPN_W-1:0] vpn, vmask,
                                            input logic g,
                                            input logic [tpr_pkg::ASID_W-1:0] asid);
      tpr_pkg::rsp_type          res;
      tpr_pkg::raw_type          r;
      logic [tpr_pkg::VPN_W-1:0] key_vpn;
      logic [7:0]                key_asid;
      int                        k;
      res      = '0;
      key_vpn  = hi[tpr_pkg::VPN_W-1:0];
      key_asid = hi[31:24];
      case (op)
         tpr_pkg::FUNC_WRITE: begin
            if (idx >= ENTRIES) begin
               res.index_bad = 1'b1;
            end else begin
               tlb_words[idx] = '{pm, hi, lo0, lo1};
               tlb_tags[idx]  = '{vpn, vmask, g, asid};
            end
         end
         tpr_pkg::FUNC_PROBE: begin
            res.probe_miss = 1'b1;
            // walk downwards so the lowest matching entry is the one left standing
            for (k = ENTRIES - 1; k >= 0; k--) begin
               if (tlb_tags[k].vpn2 == (~tlb_tags[k].mask & key_vpn) &&
                   (tlb_tags[k].glob || tlb_tags[k].asid == key_asid)) begin
                  res.probe_miss  = 1'b0;
                  res.probe_index = tpr_pkg::IDX_W'(k);
               end
            end
         end
         tpr_pkg::FUNC_READ: begin
            if (idx >= ENTRIES) begin
               res.index_bad = 1'b1;
            end else begin
               r             = tlb_words[idx];
               res.page_mask = r.page_mask;
               res.entry_hi  = r.entry_hi & ~(r.page_mask | tpr_pkg::HI_CLEAR);
               res.entry_lo0 = {r.entry_lo0[31:1], r.entry_hi[12]};
               res.entry_lo1 = {r.entry_lo1[31:1], r.entry_hi[12]};
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (slot = 0; slot < ENTRIES; slot++) begin
            tlb_words[slot] = '0;
            tlb_tags[slot]  = '0;
         end
         awaited_rsps.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsps.size() == 0) begin
               note_mismatch("unexpected transaction", '0, '0);
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_probe_miss !== want.probe_miss)
                  note_mismatch("probe_miss", 32'(rsp_probe_miss), 32'(want.probe_miss));
               if (rsp_probe_index !== want.probe_index)
                  note_mismatch("probe_index", 32'(rsp_probe_index), 32'(want.probe_index));
               if (rsp_read_page_mask !== want.page_mask)
                  note_mismatch("read_page_mask", rsp_read_page_mask, want.page_mask);
               if (rsp_read_entry_hi !== want.entry_hi)
                  note_mismatch("read_entry_hi", rsp_read_entry_hi, want.entry_hi);
               if (rsp_read_entry_lo0 !== want.entry_lo0)
                  note_mismatch("read_entry_lo0", rsp_read_entry_lo0, want.entry_lo0);
               if (rsp_read_entry_lo1 !== want.entry_lo1)
                  note_mismatch("read_entry_lo1", rsp_read_entry_lo1, want.entry_lo1);
               if (rsp_index_bad !== want.index_bad)
                  note_mismatch("index_bad", 32'(rsp_index_bad), 32'(want.index_bad));
            end
         end
         if (req_valid && req_ready)
            awaited_rsps.push_back(apply_tlb_op(req_func, req_entry_index, req_entry_hi,
                                                req_page_mask, req_entry_lo0, req_entry_lo1,
                                                req_vpn2_field, req_vpn_mask_field,
                                                req_global_bit, req_asid_field));
      end
      outstanding <= awaited_rsps.size();
   end

endmodule

FILE: test/tlb_probe_and_read_tb.sv
`timescale 1ns / 1ps

module tlb_probe_and_read_tb;

   localparam int         ENTRIES     = tpr_pkg::ENTRIES_DEF;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 600_000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_func = tpr_pkg::FUNC_WRITE;
   logic [tpr_pkg::IDX_W-1:0]  req_entry_index = '0;
   logic [31:0]                req_entry_hi = '0;
   logic [31:0]                req_page_mask = '0;
   logic [31:0]                req_entry_lo0 = '0;
   logic [31:0]                req_entry_lo1 = '0;
   logic [tpr_pkg::VPN_W-1:0]  req_vpn2_field = '0;
   logic [tpr_pkg::VPN_W-1:0]  req_vpn_mask_field = '0;
   logic                       req_global_bit = 1'b0;
   logic [tpr_pkg::ASID_W-1:0] req_asid_field = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_probe_miss;
   logic [tpr_pkg::IDX_W-1:0]  rsp_probe_index;
   logic [31:0]                rsp_read_page_mask;
   logic [31:0]                rsp_read_entry_hi;
   logic [31:0]                rsp_read_entry_lo0;
   logic [31:0]                rsp_read_entry_lo1;
   logic                       rsp_index_bad;
   int                         fail_count;
   int                         outstanding;

   int                         idle_pct = 0;
   int                         cycle_count = 0;
   int                         stall_left = 0;

   // what the stimulus has put in the table, used to aim probes at real entries
   logic [tpr_pkg::VPN_W-1:0]  known_vpn2[ENTRIES];
   logic [tpr_pkg::VPN_W-1:0]  known_mask[ENTRIES];
   logic                       known_glob[ENTRIES];
   logic [tpr_pkg::ASID_W-1:0] known_asid[ENTRIES];

   tlb_probe_and_read #(.ENTRIES(ENTRIES)) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_entry_index    (req_entry_index),
      .req_entry_hi       (req_entry_hi),
      .req_page_mask      (req_page_mask),
      .req_entry_lo0      (req_entry_lo0),
      .req_entry_lo1      (req_entry_lo1),
      .req_vpn2_field     (req_vpn2_field),
      .req_vpn_mask_field (req_vpn_mask_field),
      .req_global_bit     (req_global_bit),
      .req_asid_field     (req_asid_field),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_probe_miss     (rsp_probe_miss),
      .rsp_probe_index    (rsp_probe_index),
      .rsp_read_page_mask (rsp_read_page_mask),
      .rsp_read_entry_hi  (rsp_read_entry_hi),
      .rsp_read_entry_lo0 (rsp_read_entry_lo0),
      .rsp_read_entry_lo1 (rsp_read_entry_lo1),
      .rsp_index_bad      (rsp_index_bad)
   );

   tlb_probe_and_read_checker #(.ENTRIES(ENTRIES)) i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_entry_index    (req_entry_index),
      .req_entry_hi       (req_entry_hi),
      .req_page_mask      (req_page_mask),
      .req_entry_lo0      (req_entry_lo0),
      .req_entry_lo1      (req_entry_lo1),
      .req_vpn2_field     (req_vpn2_field),
      .req_vpn_mask_field (req_vpn_mask_field),
      .req_global_bit     (req_global_bit),
      .req_asid_field     (req_asid_field),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_probe_miss     (rsp_probe_miss),
      .rsp_probe_index    (rsp_probe_index),
      .rsp_read_page_mask (rsp_read_page_mask),
      .rsp_read_entry_hi  (rsp_read_entry_hi),
      .rsp_read_entry_lo0 (rsp_read_entry_lo0),
      .rsp_read_entry_lo1 (rsp_read_entry_lo1),
      .rsp_index_bad      (rsp_index_bad),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tlb_probe_and_read test failed");
         $finish;
      end
   end

   // receiver stalls in bursts of random length
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [tpr_pkg::IDX_W-1:0] idx,
                            input logic [31:0] hi, pm, lo0, lo1,
                            input logic [tpr_pkg::VPN_W-1:0] vpn, vmask,
                            input logic g, input logic [tpr_pkg::ASID_W-1:0] asid);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_func           <= op;
      req_entry_index    <= idx;
      req_entry_hi       <= hi;
      req_page_mask      <= pm;
      req_entry_lo0      <= lo0;
      req_entry_lo1      <= lo1;
      req_vpn2_field     <= vpn;
      req_vpn_mask_field <= vmask;
      req_global_bit     <= g;
      req_asid_field     <= asid;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == tpr_pkg::FUNC_WRITE && idx < ENTRIES) begin
         known_vpn2[idx] = vpn;
         known_mask[idx] = vmask;
         known_glob[idx] = g;
         known_asid[idx] = asid;
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic random_item();
      int                         sel;
      int                         k;
      logic [1:0]                 op;
      logic [tpr_pkg::IDX_W-1:0]  idx;
      logic [31:0]                hi;
      logic [31:0]                pm;
      logic [tpr_pkg::VPN_W-1:0]  vpn;
      logic [tpr_pkg::VPN_W-1:0]  vmask;
      logic                       g;
      logic [tpr_pkg::ASID_W-1:0] asid;
      sel = $urandom_range(0, 99);
      idx = tpr_pkg::IDX_W'($urandom);
      hi  = $urandom;
      pm  = $urandom_range(0, 1) ? $urandom : ($urandom & 32'h01ff_e000);
      case ($urandom_range(0, 3))
         1:       vmask = (tpr_pkg::VPN_W'(1) << $urandom_range(0, tpr_pkg::VPN_W - 1))
                          - tpr_pkg::VPN_W'(1);
         2:       vmask = tpr_pkg::VPN_W'($urandom);
         default: vmask = '0;
      endcase
      vpn  = tpr_pkg::VPN_W'($urandom) & ~vmask;
      g    = ($urandom_range(0, 3) == 0);
      asid = tpr_pkg::ASID_W'($urandom);
      if (sel < 35) begin
         op = tpr_pkg::FUNC_WRITE;
         if ($urandom_range(0, 9) != 0) idx = tpr_pkg::IDX_W'($urandom_range(0, ENTRIES - 1));
         // duplicate tags elsewhere so lowest-entry priority gets exercised
         if ($urandom_range(0, 4) == 0) begin
            k     = $urandom_range(0, ENTRIES - 1);
            vpn   = known_vpn2[k];
            vmask = known_mask[k];
         end else if ($urandom_range(0, 9) == 0) begin
            vpn = tpr_pkg::VPN_W'($urandom);
         end
      end else if (sel < 70) begin
         op = tpr_pkg::FUNC_PROBE;
         if ($urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, ENTRIES - 1);
            hi[tpr_pkg::VPN_W-1:0] = known_vpn2[k]
                                     | (tpr_pkg::VPN_W'($urandom) & known_mask[k]);
            if (!known_glob[k] && $urandom_range(0, 4) != 0) hi[31:24] = known_asid[k];
         end
      end else if (sel < 95) begin
         op = tpr_pkg::FUNC_READ;
         if ($urandom_range(0, 9) != 0) idx = tpr_pkg::IDX_W'($urandom_range(0, ENTRIES - 1));
      end else begin
         op = FUNC_UNUSED;
      end
      send_item(op, idx, hi, pm, $urandom, $urandom, vpn, vmask, g, asid);
   endtask

   initial begin
      int n;
      for (n = 0; n < ENTRIES; n++) begin
         known_vpn2[n] = '0;
         known_mask[n] = '0;
         known_glob[n] = 1'b0;
         known_asid[n] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 20;
      // cleared table: an all-zero key hits entry 0, all ones misses
      send_item(tpr_pkg::FUNC_PROBE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, '0, '0, 1'b0, '0);
      send_item(tpr_pkg::FUNC_PROBE, 6'd63, '1, '1, '1, '1, '1, '1, 1'b1, '1);
      send_item(tpr_pkg::FUNC_READ, 6'd0, '1, '1, '1, '1, '1, '1, 1'b1, '1);
      send_item(tpr_pkg::FUNC_READ, 6'd63, '0, '0, '0, '0, '0, '0, 1'b0, '0);
      send_item(FUNC_UNUSED, 6'd63, '1, '1, '1, '1, '1, '1, 1'b1, '1);
      send_item(tpr_pkg::FUNC_WRITE, 6'd47, '1, '1, '1, '1, '1, '1, 1'b1, '1);
      send_item(tpr_pkg::FUNC_READ, 6'd47, '0, '0, '0, '0, '0, '0, 1'b0, '0);
      send_item(tpr_pkg::FUNC_WRITE, 6'd48, '1, '1, '1, '1, '0, '0, 1'b1, '1);
      send_item(tpr_pkg::FUNC_WRITE, 6'd63, '1, '1, '1, '1, '0, '0, 1'b1, '1);
      send_item(tpr_pkg::FUNC_WRITE, 6'd0, 32'h5a01_2340, 32'h0, '1, 32'h1234_5679,
                19'h12340, '0, 1'b0, 8'h5a);
      send_item(tpr_pkg::FUNC_READ, 6'd0, '0, '0, '0, '0, '0, '0, 1'b0, '0);
      send_item(tpr_pkg::FUNC_PROBE, 6'd0, 32'h5a01_2340, '0, '0, '0, '0, '0, 1'b0, '0);
      send_item(tpr_pkg::FUNC_PROBE, 6'd0, 32'h5b01_2340, '0, '0, '0, '0, '0, 1'b0, '0);
      send_item(tpr_pkg::FUNC_WRITE, 6'd3, 32'h1100_0100, 32'h0001_e000, '0, '0,
                19'h00100, 19'h000ff, 1'b0, 8'h11);
      send_item(tpr_pkg::FUNC_WRITE, 6'd5, 32'h0000_0100, 32'h0, '0, '0,
                19'h00100, '0, 1'b1, 8'h00);
      // masked match on entry 3, then asid mismatch falls through to global entry 5
      send_item(tpr_pkg::FUNC_PROBE, 6'd0, 32'h1100_01ab, '0, '0, '0, '0, '0, 1'b0, '0);
      send_item(tpr_pkg::FUNC_PROBE, 6'd0, 32'h2200_0100, '0, '0, '0, '0, '0, 1'b0, '0);
      send_item(tpr_pkg::FUNC_READ, 6'd3, '0, '0, '0, '0, '0, '0, 1'b0, '0);
      send_item(tpr_pkg::FUNC_WRITE, 6'd47, 32'h0007_ff00 | 32'h1000, 32'h0, 32'hffff_fffe,
                '0, 19'h7ff00, '0, 1'b1, 8'h00);
      send_item(tpr_pkg::FUNC_PROBE, 6'd0, 32'h9907_ff00, '0, '0, '0, '0, '0, 1'b0, '0);
      send_item(tpr_pkg::FUNC_READ, 6'd47, '0, '0, '0, '0, '0, '0, 1'b0, '0);
      send_item(tpr_pkg::FUNC_READ, 6'd48, '0, '0, '0, '0, '0, '0, 1'b0, '0);
      drain_results();

      for (n = 0; n < 1200; n++) begin
         if (n % 150 == 0) begin
            if (n >= 1050) idle_pct = 0;
            else begin
               case ($urandom_range(0, 2))
                  0:       idle_pct = 0;
                  1:       idle_pct = 15;
                  default: idle_pct = 40;
               endcase
            end
         end
         if (n > 0 && n % 400 == 0) drain_results();
         random_item();
      end
      drain_results();
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("tlb_probe_and_read test passed");
      else
         $display("tlb_probe_and_read test failed");
      $finish;
   end

endmodule
